// ===== sv/pool2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pool2d_pkg
// Shared types and constants of the streaming 2-D max / average pooling block.
// ----------------------------------------------------------------------------
package pool2d_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_KERNEL_DEF = 8;
  localparam int DATA_BITS_DEF  = 16;

  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;
  localparam int H_W        = 13;
  localparam int PW_W       = 8;
  localparam int K_W        = 4;
  localparam int STRIDE_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PADDED_WIDTH  = 3'd0,
    REG_PADDED_HEIGHT = 3'd1,
    REG_KERNEL_WIDTH  = 3'd2,
    REG_KERNEL_HEIGHT = 3'd3,
    REG_STRIDE_COLS   = 3'd4,
    REG_STRIDE_ROWS   = 3'd5,
    REG_POOL_KIND     = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_RECALC,
    ST_READ,
    ST_DRAIN,
    ST_DIV,
    ST_FINISH
  } pool_state_t;

endpackage
`default_nettype wire

// ===== sv/pool2d_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pool2d_store
// Line store: one word per column holding every row slot, slot-wise write,
// whole-column read, registered.
// ----------------------------------------------------------------------------
module pool2d_store #(
  parameter int COLS    = 128,
  parameter int SLOTS   = 8,
  parameter int ENTRY_W = 17
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [$clog2(COLS)-1:0]                waddr,
  input  wire logic [$clog2(SLOTS)-1:0]               wslot,
  input  wire logic [ENTRY_W-1:0]                     wdata,
  input  wire logic                                   re,
  input  wire logic [$clog2(COLS)-1:0]                raddr,
  output logic      [SLOTS-1:0][ENTRY_W-1:0]          rdata
);

  logic [SLOTS-1:0][ENTRY_W-1:0] mem [COLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][wslot] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/pool2d_colred.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pool2d_colred
// Column reduction: max, sum and count of the real samples of one stored
// column inside the window rows, registered.
// ----------------------------------------------------------------------------
module pool2d_colred #(
  parameter int SLOTS     = 8,
  parameter int DATA_BITS = 16,
  parameter int SUM_W     = 22,
  parameter int CNT_W     = 7
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_vld,
  input  wire logic [SLOTS-1:0][DATA_BITS:0]         word,
  input  wire logic [SLOTS-1:0]                      mask,
  output logic                                       cr_vld,
  output logic signed [DATA_BITS-1:0]                cr_max,
  output logic signed [SUM_W-1:0]                    cr_sum,
  output logic        [CNT_W-1:0]                    cr_cnt
);

  logic signed [DATA_BITS-1:0] best;
  logic signed [SUM_W-1:0]     sum;
  logic        [CNT_W-1:0]     cnt;

  always_comb begin
    logic signed [DATA_BITS-1:0] v;
    best = {1'b1, {(DATA_BITS-1){1'b0}}};
    sum  = '0;
    cnt  = '0;
    for (int k = 0; k < SLOTS; k++) begin
      v = signed'(word[k][DATA_BITS-1:0]);
      if (mask[k] && !word[k][DATA_BITS]) begin
        if (cnt == '0 || v > best) begin
          best = v;
        end
        sum = sum + SUM_W'(v);
        cnt = cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cr_vld <= 1'b0;
    end else begin
      cr_vld <= in_vld;
    end
    cr_max <= best;
    cr_sum <= sum;
    cr_cnt <= cnt;
  end

endmodule
`default_nettype wire

// ===== sv/pool2d_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pool2d_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pool2d_div #(
  parameter int DW = 22,
  parameter int VW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic      [DW-1:0] quotient
);

  localparam int STEP_W = $clog2(DW + 1);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [VW-1:0]     rem;
  logic [VW:0]       trial;
  logic              qbit;

  always_comb begin
    trial = {rem, quotient[DW-1]};
    qbit  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && step == STEP_W'(DW - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      step     <= '0;
    end else if (running) begin
      quotient <= {quotient[DW-2:0], qbit};
      rem      <= qbit ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
      step     <= step + STEP_W'(1);
    end
  end

endmodule
`default_nettype wire

// ===== sv/pooling_2d_max_avg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pooling_2d_max_avg
// Streaming 2-D max / average pooling over a padded plane in raster order.
//
//   channel  direction  handshake            beat
//   in       to block   in_valid/in_ready    sample, is_pad
//   out      from block out_valid/out_ready  pooled_value, empty_window,
//                                            plane_done
//   cfg      to block   cfg_we               cfg_index, cfg_data
//
// A beat that completes a window reads kernel_width columns of the line
// store, one per cycle, then waits while the store read register and the
// column reduction register drain, and then loads the result register once
// it is free; average pooling runs the divider before the load. After any
// register write, beats wait while the counters are normalised and the stride
// phases are rebuilt. Reset clears counters and control; the line store is
// not cleared. The result register frees the core while it waits for
// out_ready.
// ----------------------------------------------------------------------------
module pooling_2d_max_avg #(
  parameter int MAX_WIDTH  = pool2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = pool2d_pkg::MAX_KERNEL_DEF,
  parameter int DATA_BITS  = pool2d_pkg::DATA_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [DATA_BITS-1:0]         sample,
  input  wire logic                                is_pad,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [DATA_BITS-1:0]              pooled_value,
  output logic                                     empty_window,
  output logic                                     plane_done,
  input  wire logic                                cfg_we,
  input  wire logic [pool2d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pool2d_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import pool2d_pkg::*;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int KW_W    = $clog2(MAX_KERNEL + 1);
  localparam int SL_W    = $clog2(MAX_KERNEL);
  localparam int ENTRY_W = DATA_BITS + 1;
  localparam int SUM_W   = DATA_BITS + $clog2(MAX_KERNEL * MAX_KERNEL);
  localparam int CNT_W   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int RC_W    = $clog2(ROW_W);

  // Configuration registers.
  logic [PW_W-1:0]     padded_width;
  logic [H_W-1:0]      padded_height;
  logic [K_W-1:0]      kernel_width;
  logic [K_W-1:0]      kernel_height;
  logic [STRIDE_W-1:0] stride_cols;
  logic [STRIDE_W-1:0] stride_rows;
  logic                pool_kind;
  logic                dirty;

  always_ff @(posedge clk) begin
    if (rst) begin
      padded_width  <= PW_W'(1);
      padded_height <= H_W'(1);
      kernel_width  <= K_W'(1);
      kernel_height <= K_W'(1);
      stride_cols   <= STRIDE_W'(1);
      stride_rows   <= STRIDE_W'(1);
      pool_kind     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PADDED_WIDTH:  padded_width  <= cfg_data[PW_W-1:0];
        REG_PADDED_HEIGHT: padded_height <= cfg_data[H_W-1:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[K_W-1:0];
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[K_W-1:0];
        REG_STRIDE_COLS:   stride_cols   <= cfg_data[STRIDE_W-1:0];
        REG_STRIDE_ROWS:   stride_rows   <= cfg_data[STRIDE_W-1:0];
        REG_POOL_KIND:     pool_kind     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Registers saturated to their legal ranges.
  logic [WW-1:0]       w_eff;
  logic [H_W-1:0]      h_eff;
  logic [KW_W-1:0]     kw_eff;
  logic [KW_W-1:0]     kh_eff;
  logic [STRIDE_W-1:0] sc_eff;
  logic [STRIDE_W-1:0] sr_eff;

  always_comb begin
    if (padded_width == '0) begin
      w_eff = WW'(1);
    end else if (int'(padded_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(padded_width);
    end
    if (padded_height == '0) begin
      h_eff = H_W'(1);
    end else if (int'(padded_height) > MAX_HEIGHT) begin
      h_eff = H_W'(MAX_HEIGHT);
    end else begin
      h_eff = padded_height;
    end
    if (kernel_width == '0) begin
      kw_eff = KW_W'(1);
    end else if (int'(kernel_width) > MAX_KERNEL) begin
      kw_eff = KW_W'(MAX_KERNEL);
    end else begin
      kw_eff = KW_W'(kernel_width);
    end
    if (kernel_height == '0) begin
      kh_eff = KW_W'(1);
    end else if (int'(kernel_height) > MAX_KERNEL) begin
      kh_eff = KW_W'(MAX_KERNEL);
    end else begin
      kh_eff = KW_W'(kernel_height);
    end
    sc_eff = (stride_cols == '0) ? STRIDE_W'(1) : stride_cols;
    sr_eff = (stride_rows == '0) ? STRIDE_W'(1) : stride_rows;
  end

  // Position state. The phases hold (position - (kernel - 1)) mod stride and
  // are meaningful once the position has reached kernel - 1.
  pool_state_t         state;
  pool_state_t         state_next;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic [SL_W-1:0]     slot;
  logic [STRIDE_W-1:0] col_ph;
  logic [STRIDE_W-1:0] row_ph;
  logic [RC_W-1:0]     rc_cnt;

  logic                in_acc;
  logic                aligned;
  logic                last_win;
  logic [MAX_KERNEL-1:0] mask_n;
  logic                col_end;
  logic                row_end;
  logic [COL_W-1:0]    col_n;
  logic [STRIDE_W-1:0] col_ph_n;
  logic [ROW_W-1:0]    row_n;
  logic [STRIDE_W-1:0] row_ph_n;
  logic [SL_W-1:0]     slot_n;
  logic [ROW_W-1:0]    xr;
  logic [ROW_W-1:0]    xc;
  logic [RC_W-1:0]     rc_bit;
  logic [STRIDE_W:0]   tr;
  logic [STRIDE_W:0]   tc;

  assign in_acc = in_valid && in_ready;

  always_comb begin
    int slot_gap;
    aligned  = (int'(row) >= int'(kh_eff) - 1) && (int'(col) >= int'(kw_eff) - 1) &&
               (row_ph == '0) && (col_ph == '0);
    last_win = (int'(row) + 1 + int'(sr_eff) > int'(h_eff)) &&
               (int'(col) + 1 + int'(sc_eff) > int'(w_eff));
    for (int k = 0; k < MAX_KERNEL; k++) begin
      slot_gap = (int'(slot) >= k) ? int'(slot) - k : int'(slot) + MAX_KERNEL - k;
      mask_n[k] = (slot_gap < int'(kh_eff));
    end
    col_end  = (int'(col) + 1 >= int'(w_eff));
    col_n    = col_end ? '0 : col + COL_W'(1);
    if (int'(col_n) == int'(kw_eff) - 1) begin
      col_ph_n = '0;
    end else begin
      col_ph_n = (col_ph + STRIDE_W'(1) == sc_eff) ? '0 : col_ph + STRIDE_W'(1);
    end
    row_end  = (int'(row) + 1 >= int'(h_eff));
    row_n    = row_end ? '0 : row + ROW_W'(1);
    if (row_end) begin
      slot_n = '0;
    end else begin
      slot_n = (int'(slot) == MAX_KERNEL - 1) ? '0 : slot + SL_W'(1);
    end
    if (int'(row_n) == int'(kh_eff) - 1) begin
      row_ph_n = '0;
    end else begin
      row_ph_n = (row_ph + STRIDE_W'(1) == sr_eff) ? '0 : row_ph + STRIDE_W'(1);
    end
    // Bit-serial remainder used to rebuild the phases after a register write.
    xr     = ROW_W'(int'(row) - (int'(kh_eff) - 1));
    xc     = ROW_W'(int'(col) - (int'(kw_eff) - 1));
    rc_bit = RC_W'(ROW_W - 1) - rc_cnt;
    tr     = {row_ph, xr[rc_bit]};
    tc     = {col_ph, xc[rc_bit]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      slot   <= '0;
      col_ph <= '0;
      row_ph <= '0;
      rc_cnt <= '0;
    end else if (state == ST_NORM) begin
      if (int'(col) >= int'(w_eff)) begin
        col <= '0;
      end
      if (int'(row) >= int'(h_eff)) begin
        row  <= '0;
        slot <= '0;
      end
      col_ph <= '0;
      row_ph <= '0;
      rc_cnt <= '0;
    end else if (state == ST_RECALC) begin
      row_ph <= (tr >= {1'b0, sr_eff}) ? STRIDE_W'(tr - {1'b0, sr_eff}) : tr[STRIDE_W-1:0];
      col_ph <= (tc >= {1'b0, sc_eff}) ? STRIDE_W'(tc - {1'b0, sc_eff}) : tc[STRIDE_W-1:0];
      rc_cnt <= rc_cnt + RC_W'(1);
    end else if (in_acc) begin
      col    <= col_n;
      col_ph <= col_ph_n;
      if (col_end) begin
        row    <= row_n;
        slot   <= slot_n;
        row_ph <= row_ph_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b0;
    end else if (cfg_we) begin
      dirty <= 1'b1;
    end else if (state == ST_RECALC && rc_cnt == RC_W'(ROW_W - 1)) begin
      dirty <= 1'b0;
    end
  end

  // Window walk over the stored columns.
  logic [MAX_KERNEL-1:0] win_mask;
  logic                  win_last;
  logic [COL_W-1:0]      rd_col;
  logic [KW_W-1:0]       rd_left;
  logic                  rd_vld;
  logic                  out_load;
  logic                  div_start;
  logic                  div_done;
  logic [SUM_W-1:0]      quotient;

  logic [MAX_KERNEL-1:0][ENTRY_W-1:0] rdata;
  logic                               cr_vld;
  logic signed [DATA_BITS-1:0]        cr_max;
  logic signed [SUM_W-1:0]            cr_sum;
  logic        [CNT_W-1:0]            cr_cnt;

  logic signed [DATA_BITS-1:0] acc_best;
  logic signed [SUM_W-1:0]     acc_sum;
  logic        [CNT_W-1:0]     acc_cnt;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_mask <= mask_n;
      win_last <= last_win;
      rd_col   <= COL_W'(int'(col) - (int'(kw_eff) - 1));
      rd_left  <= kw_eff - KW_W'(1);
    end else if (state == ST_READ) begin
      rd_col  <= rd_col + COL_W'(1);
      rd_left <= rd_left - KW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_best <= {1'b1, {(DATA_BITS-1){1'b0}}};
      acc_sum  <= '0;
      acc_cnt  <= '0;
    end else if (cr_vld) begin
      if (cr_cnt != '0 && (acc_cnt == '0 || cr_max > acc_best)) begin
        acc_best <= cr_max;
      end
      acc_sum <= acc_sum + cr_sum;
      acc_cnt <= acc_cnt + cr_cnt;
    end
  end

  pool2d_store #(
    .COLS    (MAX_WIDTH),
    .SLOTS   (MAX_KERNEL),
    .ENTRY_W (ENTRY_W)
  ) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col),
    .wslot (slot),
    .wdata ({is_pad, sample}),
    .re    (state == ST_READ),
    .raddr (rd_col),
    .rdata (rdata)
  );

  pool2d_colred #(
    .SLOTS     (MAX_KERNEL),
    .DATA_BITS (DATA_BITS),
    .SUM_W     (SUM_W),
    .CNT_W     (CNT_W)
  ) u_colred (
    .clk    (clk),
    .rst    (rst),
    .in_vld (rd_vld),
    .word   (rdata),
    .mask   (win_mask),
    .cr_vld (cr_vld),
    .cr_max (cr_max),
    .cr_sum (cr_sum),
    .cr_cnt (cr_cnt)
  );

  // Average: divide the magnitude, then restore the sign (rounds toward zero).
  logic             sum_neg;
  logic [SUM_W-1:0] sum_mag;
  logic [SUM_W-1:0] avg_full;

  assign sum_neg  = acc_sum[SUM_W-1];
  assign sum_mag  = sum_neg ? SUM_W'(-acc_sum) : SUM_W'(acc_sum);
  assign avg_full = sum_neg ? SUM_W'(-quotient) : quotient;

  pool2d_div #(
    .DW (SUM_W),
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (acc_cnt),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !dirty;
        if (dirty && !cfg_we) begin
          state_next = ST_NORM;
        end else if (in_acc && aligned) begin
          state_next = ST_READ;
        end
      end
      ST_NORM: begin
        state_next = cfg_we ? ST_IDLE : ST_RECALC;
      end
      ST_RECALC: begin
        if (cfg_we || rc_cnt == RC_W'(ROW_W - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (rd_left == '0) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld && !cr_vld) begin
          if (pool_kind && acc_cnt != '0) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      if (!pool_kind) begin
        pooled_value <= acc_best;
      end else if (acc_cnt == '0) begin
        pooled_value <= '0;
      end else begin
        pooled_value <= signed'(avg_full[DATA_BITS-1:0]);
      end
      empty_window <= (acc_cnt == '0);
      plane_done   <= win_last;
    end
  end

  a_div_needs_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> pool_kind && acc_cnt != '0)
    else $error("divider running without an average to form");

  a_reduce_in_window: assert property (@(posedge clk) disable iff (rst)
    cr_vld |-> state == ST_READ || state == ST_DRAIN)
    else $error("column reduction outside a window walk");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |-> int'(acc_cnt) <= int'(kw_eff) * int'(kh_eff))
    else $error("window count exceeds window size");

  a_window_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc && aligned |=> state == ST_READ)
    else $error("aligned beat did not start a window walk");

endmodule
`default_nettype wire

// ===== verif/pool2d_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool2d_checker
// Watches the sample, result and register ports of the pooling block, keeps
// its own copy of the line store and counters, predicts every window result
// and compares each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module pool2d_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [15:0]                sample,
  input  logic                              is_pad,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [15:0]                pooled_value,
  input  logic                              empty_window,
  input  logic                              plane_done,
  input  logic                              cfg_we,
  input  logic [pool2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pool2d_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                mismatches,
  output int                                pending,
  output int                                windows_checked
);

  import pool2d_pkg::*;

  typedef struct packed {
    logic signed [15:0] value;
    logic               empty;
    logic               last;
  } window_t;

  localparam int NK = MAX_KERNEL_DEF;
  localparam int NW = MAX_WIDTH_DEF;

  logic [7:0]  pw_reg;
  logic [12:0] ph_reg;
  logic [3:0]  kw_reg, kh_reg, sc_reg, sr_reg;
  logic        kind_reg;
  logic [16:0] line_mem [NK*NW];
  int          row_pos, col_pos;
  window_t     expected_windows[$];

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Stores one sample and returns 1 with the window result when it closes one.
  function automatic bit pool_step(logic signed [15:0] s, logic pad, output window_t res);
    int w, h, kw, kh, sc, sr, r, c, r0, c0, cnt, best, sum, v;
    logic [16:0] e;
    w  = clip(int'(pw_reg), 1, NW);
    h  = clip(int'(ph_reg), 1, MAX_HEIGHT);
    kw = clip(int'(kw_reg), 1, NK);
    kh = clip(int'(kh_reg), 1, NK);
    sc = clip(int'(sc_reg), 1, 15);
    sr = clip(int'(sr_reg), 1, 15);
    pool_step = 0;
    res = '0;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    line_mem[(r % NK) * NW + c] = {pad, s};
    if (r + 1 >= kh && c + 1 >= kw && (r + 1 - kh) % sr == 0 && (c + 1 - kw) % sc == 0) begin
      r0 = r + 1 - kh;
      c0 = c + 1 - kw;
      best = -32768;
      sum = 0;
      cnt = 0;
      for (int i = 0; i < kh; i++) begin
        for (int j = 0; j < kw; j++) begin
          e = line_mem[((r0 + i) % NK) * NW + c0 + j];
          if (!e[16]) begin
            v = int'($signed(e[15:0]));
            if (cnt == 0 || v > best) best = v;
            sum += v;
            cnt++;
          end
        end
      end
      res.value = 16'(kind_reg ? ((cnt != 0) ? sum / cnt : 0) : best);
      res.empty = (cnt == 0);
      res.last  = (r0 == ((h - kh) / sr) * sr) && (c0 == ((w - kw) / sc) * sc);
      pool_step = 1;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  always @(posedge clk) begin
    window_t want, got;
    if (rst) begin
      pw_reg = 1; ph_reg = 1; kw_reg = 1; kh_reg = 1;
      sc_reg = 1; sr_reg = 1; kind_reg = 0;
      row_pos = 0; col_pos = 0;
      expected_windows.delete();
      mismatches = 0;
      windows_checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{pooled_value, empty_window, plane_done};
        if (expected_windows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: value %0d empty %0b last %0b",
                     got.value, got.empty, got.last);
        end else begin
          want = expected_windows.pop_front();
          windows_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected value %0d empty %0b last %0b, got %0d %0b %0b",
                       windows_checked, want.value, want.empty, want.last,
                       got.value, got.empty, got.last);
          end
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_PADDED_WIDTH:  pw_reg   = cfg_data[7:0];
          REG_PADDED_HEIGHT: ph_reg   = cfg_data[12:0];
          REG_KERNEL_WIDTH:  kw_reg   = cfg_data[3:0];
          REG_KERNEL_HEIGHT: kh_reg   = cfg_data[3:0];
          REG_STRIDE_COLS:   sc_reg   = cfg_data[3:0];
          REG_STRIDE_ROWS:   sr_reg   = cfg_data[3:0];
          REG_POOL_KIND:     kind_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (pool_step(sample, is_pad, want)) expected_windows.push_back(want);
      end
    end
    pending = expected_windows.size();
  end

endmodule

// ===== verif/tb_pooling_2d_max_avg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pooling_2d_max_avg
// Drives padded feature planes through the pooling block under a series of
// register settings, with random gaps on both channels and one long output
// stall, and reports the verdict from the attached checker.
// ----------------------------------------------------------------------------
module tb_pooling_2d_max_avg;
  import pool2d_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  in_valid = 0;
  logic                  in_ready;
  logic signed [15:0]    sample = '0;
  logic                  is_pad = 0;
  logic                  out_valid;
  logic                  out_ready = 0;
  logic signed [15:0]    pooled_value;
  logic                  empty_window;
  logic                  plane_done;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches, pending, windows_checked;
  int cycles = 0;
  int beats_sent = 0;
  int settings_used = 0;
  int plane_w = 1, plane_h = 1;
  int hold_left = 0;
  bit hold_done = 0;

  pooling_2d_max_avg u_top (.*);

  pool2d_checker u_checker (.*);

  always #5 clk = ~clk;

  // Idle mix: sender light and receiver heavy, then reversed, then none.
  function automatic int sender_idle_pct();
    return (beats_sent < 500) ? 6 : (beats_sent < 1000) ? 64 : 0;
  endfunction

  function automatic int receiver_stall_pct();
    return (beats_sent < 500) ? 64 : (beats_sent < 1000) ? 6 : 0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One long output stall while samples keep coming, so the block backs up.
  // It starts inside the last row of the wide plane, where windows are dense.
  always @(posedge clk) begin
    if (!hold_done && beats_sent >= 600) begin
      hold_left <= 600;
      hold_done <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    out_ready <= !rst && hold_left == 0 && ($urandom_range(99) >= receiver_stall_pct());
  end

  task automatic send_beat(logic signed [15:0] s, logic pad);
    if ($urandom_range(99) < sender_idle_pct()) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    sample   <= s;
    is_pad   <= pad;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (64) @(posedge clk);
  endtask

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic write_regs(int pw, int ph, int kw, int kh, int sc, int sr, int kind);
    int vals [7];
    vals = '{pw, ph, kw, kh, sc, sr, kind};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 0;
    plane_w = clip(pw & 8'hff, 1, 128);
    plane_h = clip(ph & 13'h1fff, 1, MAX_HEIGHT);
    settings_used++;
  endtask

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return -$signed(16'($urandom_range(3)));
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends rows of the current plane: a pad frame of border width, plus random pads.
  task automatic send_rows(int rows, int border, int pad_pct);
    bit pad;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < plane_w; c++) begin
        pad = (r % plane_h) < border || (r % plane_h) >= plane_h - border ||
              c < border || c >= plane_w - border || $urandom_range(99) < pad_pct;
        send_beat(random_sample(), pad);
      end
    end
  endtask

  initial begin
    int pw, ph;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes in 2x2 windows with stride 2, max then average.
    write_regs(4, 4, 2, 2, 2, 2, 0);
    send_beat(16'sh7fff, 0); send_beat(16'sh8000, 0); send_beat(16'sh1234, 1);
    send_beat(16'sh0001, 1); send_beat(16'sh8000, 0); send_beat(16'sh8000, 0);
    send_beat(16'sh7fff, 1); send_beat(16'sh0005, 1);
    send_beat(16'sh7fff, 0); send_beat(-16'sh0003, 0); send_beat(16'sh0002, 0);
    send_beat(16'sh0001, 0); send_beat(-16'sh0001, 0); send_beat(16'sh7fff, 0);
    send_beat(16'sh0002, 0); send_beat(16'sh0001, 1);
    wait_idle();
    write_regs(4, 4, 2, 2, 2, 2, 1);
    send_rows(4, 0, 30);
    send_rows(4, 1, 0);
    wait_idle();
    // Window larger than the plane, with out-of-range kernel and zero stride.
    write_regs(3, 3, 15, 9, 0, 0, 1);
    send_rows(3, 0, 0);
    // Stop mid-plane, then shrink the plane below both counters.
    wait_idle();
    write_regs(8, 8, 3, 2, 1, 1, 0);
    send_rows(3, 0, 20);
    for (int c = 0; c < 5; c++) send_beat(random_sample(), 0);
    wait_idle();
    write_regs(4, 3, 2, 2, 1, 1, 1);
    send_rows(6, 0, 20);
    wait_idle();
    // Tallest plane (its top rows only) and widest plane through saturated values.
    write_regs(0, 8191, 1, 8, 9, 8, 0);
    send_rows(200, 0, 10);
    wait_idle();
    write_regs(255, 3, 8, 3, 8, 1, 1);
    send_rows(3, 0, 10);
    wait_idle();

    // Random settings, whole planes each.
    while (beats_sent < 1400) begin
      if ($urandom_range(9) == 0) begin
        pw = $urandom_range(255);
        ph = $urandom_range(1, 2);
      end else begin
        pw = $urandom_range(1, 24);
        ph = $urandom_range(1, 14);
      end
      write_regs(pw, ph, $urandom_range(15), $urandom_range(15),
                 $urandom_range(15), $urandom_range(15), $urandom_range(1));
      send_rows(plane_h * $urandom_range(1, 2), $urandom_range(2), $urandom_range(40));
      wait_idle();
    end

    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d samples under %0d register settings; %0d window results checked.",
             beats_sent, settings_used, windows_checked);
    $display("Covered max and average pooling, pad frames, empty windows and saturation.");
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
